// ----- rtl/glyph_range_index_lookup_macros.svh -----
// Assertion macros used by the checker file.
`ifndef GLYPH_RANGE_INDEX_LOOKUP_MACROS_SVH
`define GLYPH_RANGE_INDEX_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GRLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define GRLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/grli_pkg.sv -----
// Shared constants, types and helpers for the glyph range index lookup.
`default_nettype none
package grli_pkg;

    localparam int MAX_RANGES = 64;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int CODE_W     = 16;
    localparam int CAND_W     = 2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [CAND_W-1:0] CAND_INPUT = 2'd0;
    localparam logic [CAND_W-1:0] CAND_REPL  = 2'd1;
    localparam logic [CAND_W-1:0] CAND_QMARK = 2'd2;
    localparam logic [CAND_W-1:0] CAND_SPACE = 2'd3;

    localparam logic [CODE_W-1:0] CODE_REPL  = 16'hFFFD;
    localparam logic [CODE_W-1:0] CODE_QMARK = 16'h003F;
    localparam logic [CODE_W-1:0] CODE_SPACE = 16'h0020;

    typedef struct packed {
        logic [CODE_W-1:0] start;
        logic [CODE_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_tbl_wr;

    typedef struct packed {
        logic              go;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  limit;
    } t_walk_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              found;
        logic [CODE_W-1:0] index;
    } t_walk_rsp;

    function automatic logic [CODE_W-1:0] fallback_code(input logic [CAND_W-1:0] cand);
        logic [CODE_W-1:0] c;
        case (cand)
            CAND_REPL:  c = CODE_REPL;
            CAND_QMARK: c = CODE_QMARK;
            CAND_SPACE: c = CODE_SPACE;
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/grli_table.sv -----
// Range table memory: one write port, one registered read port.
`default_nettype none
module grli_table (
    input  wire                       i_clk,
    input  grli_pkg::t_tbl_wr         i_wr,
    input  wire [grli_pkg::IDX_W-1:0] i_rd_addr,
    output grli_pkg::t_entry          o_rd_data
);
    import grli_pkg::*;

    t_entry r_mem [MAX_RANGES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- rtl/grli_walker.sv -----
// Sequencer and shared compare/add unit that walks the range table.
`default_nettype none
module grli_walker (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  grli_pkg::t_walk_req       i_req,
    input  grli_pkg::t_entry          i_rd_data,
    output logic [grli_pkg::IDX_W-1:0] o_rd_addr,
    output grli_pkg::t_walk_rsp       o_rsp
);
    import grli_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic              r_state, n_state;
    logic [CAND_W-1:0] r_cand,  n_cand;
    logic [CODE_W-1:0] r_code,  n_code;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    logic [CODE_W-1:0] r_sum,   n_sum;
    logic [CNT_W-1:0]  r_limit, n_limit;
    logic              r_done,  n_done;
    logic              r_found, n_found;
    logic [CODE_W-1:0] r_index, n_index;

    logic [CODE_W-1:0] cand_code;
    logic [CODE_W:0]   range_end;
    logic              below;
    logic              hit;
    logic              last;

    // Shared unit: one compare against start, one against start + length.
    assign cand_code = (r_cand == CAND_INPUT) ? r_code : fallback_code(r_cand);
    assign range_end = {1'b0, i_rd_data.start} + {1'b0, i_rd_data.length};
    assign below     = cand_code < i_rd_data.start;
    assign hit       = ({1'b0, cand_code} < range_end);
    assign last      = (CNT_W'(r_idx) + CNT_W'(1)) == r_limit;

    always_comb begin
        n_state   = r_state;
        n_cand    = r_cand;
        n_code    = r_code;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_limit   = r_limit;
        n_done    = 1'b0;
        n_found   = r_found;
        n_index   = r_index;
        o_rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_code  = i_req.code;
                    n_limit = i_req.limit;
                    n_cand  = CAND_INPUT;
                    n_idx   = '0;
                    n_sum   = '0;
                    if (i_req.limit == '0) begin
                        // empty table: every candidate misses at once
                        n_done  = 1'b1;
                        n_found = 1'b0;
                        n_index = '0;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (below || (!hit && last)) begin
                    if (r_cand == CAND_SPACE) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        n_found = 1'b0;
                        n_index = '0;
                    end else begin
                        // next fallback restarts at entry 0
                        n_cand = r_cand + CAND_W'(1);
                        n_idx  = '0;
                        n_sum  = '0;
                    end
                end else if (hit) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_index = r_sum + (cand_code - i_rd_data.start);
                end else begin
                    n_sum     = r_sum + i_rd_data.length;
                    n_idx     = r_idx + IDX_W'(1);
                    o_rd_addr = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_code  <= n_code;
        r_idx   <= n_idx;
        r_sum   <= n_sum;
        r_limit <= n_limit;
        r_found <= n_found;
        r_index <= n_index;
    end

    assign o_rsp.busy  = (r_state != S_IDLE);
    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_rsp.index = r_index;

endmodule
`default_nettype wire

// ----- rtl/glyph_range_index_lookup.sv -----
// Top level: request decode, range count register and result strobe.
`default_nettype none
// Maps a 16-bit character code to a glyph index through a table of up to
// 64 ascending code ranges. A request with i_kind = 0 writes one table entry
// and returns nothing; busy stays low. A request with i_kind = 1 walks the
// table one entry per clock, through a single compare and add unit fed by
// the registered table read port, and on a miss retries with U+FFFD, '?'
// and space. A lookup holds busy high while it walks, and its result
// appears on o_valid in the cycle busy falls (an empty table answers in the
// next cycle and never raises busy). o_valid is a single-cycle strobe and
// the receiver cannot stall it. Write the range count only while busy is
// low; table contents have no reset and must be loaded before use.
module glyph_range_index_lookup (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire                        i_kind,
    input  wire [5:0]                  i_range_slot,
    input  wire [grli_pkg::CODE_W-1:0] i_range_start,
    input  wire [grli_pkg::CODE_W-1:0] i_range_length,
    input  wire [grli_pkg::CODE_W-1:0] i_code,
    input  wire                        i_cfg_we,
    input  wire [6:0]                  i_cfg_wdata,
    output logic                       o_valid,
    output logic                       o_found,
    output logic [grli_pkg::CODE_W-1:0] o_glyph_index
);
    import grli_pkg::*;

    logic [6:0]       r_num_ranges;
    logic [CNT_W-1:0] limit;
    logic             accept;
    t_tbl_wr          tbl_wr;
    t_walk_req        walk_req;
    t_walk_rsp        walk_rsp;
    t_entry           rd_data;
    logic [IDX_W-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ranges <= '0;
        end else if (i_cfg_we) begin
            r_num_ranges <= i_cfg_wdata;
        end
    end

    // counts beyond the table size walk the whole table
    assign limit = (32'(r_num_ranges) > MAX_RANGES) ? CNT_W'(MAX_RANGES)
                                                    : CNT_W'(r_num_ranges);

    assign accept = start && !busy;

    assign tbl_wr.en           = accept && (i_kind == KIND_LOAD)
                                 && (32'(i_range_slot) < MAX_RANGES);
    assign tbl_wr.addr         = IDX_W'(i_range_slot);
    assign tbl_wr.entry.start  = i_range_start;
    assign tbl_wr.entry.length = i_range_length;

    assign walk_req.go    = accept && (i_kind == KIND_LOOKUP);
    assign walk_req.code  = i_code;
    assign walk_req.limit = limit;

    grli_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    grli_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (walk_req),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_rsp     (walk_rsp)
    );

    assign busy          = walk_rsp.busy;
    assign o_valid       = walk_rsp.done;
    assign o_found       = walk_rsp.found;
    assign o_glyph_index = walk_rsp.index;

endmodule
`default_nettype wire

// ----- rtl/grli_checker.sv -----
// Port-level checks for the glyph range index lookup, bound to the top level.
`default_nettype none
`include "glyph_range_index_lookup_macros.svh"
module grli_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        i_kind,
    input wire        o_valid,
    input wire        o_found,
    input wire [15:0] o_glyph_index
);
    import grli_pkg::*;

    `GRLI_ASSERT_NEXT(a_load_not_busy, start && !busy && (i_kind == KIND_LOAD), !busy && !o_valid, "load request made the block busy or strobe a result")
    `GRLI_ASSERT_NEXT(a_lookup_busy, start && !busy && (i_kind == KIND_LOOKUP), busy || o_valid, "lookup request neither started a walk nor answered")
    `GRLI_ASSERT_NOW(a_strobe_idle, o_valid, !busy, "result strobed while a walk is still running")
    `GRLI_ASSERT_NOW(a_miss_zero, o_valid && !o_found, o_glyph_index == 16'd0, "miss returned a nonzero glyph index")

endmodule

bind glyph_range_index_lookup grli_checker u_grli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_kind        (i_kind),
    .o_valid       (o_valid),
    .o_found       (o_found),
    .o_glyph_index (o_glyph_index)
);
`default_nettype wire
